// ----- sv/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // input queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam int ROUNDS    = 64;
  localparam int ROUND_W   = $clog2(ROUNDS);
  localparam int CNT_W     = 61;   // byte count, bit count is this times eight
  localparam int DIGEST_W  = 256;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // one queued input word
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } q_entry_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_COMP,
    ST_FIN
  } state_t;

  // what the block in the compression unit is
  typedef enum logic [1:0] {
    BK_DATA,
    BK_PAD,
    BK_FINAL
  } blk_kind_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- sv/sha256_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_front
// Accepts input words, drops empty non-closing ones and queues the rest.
// ----------------------------------------------------------------------------
module sha256_front import sha256_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // has_byte
  input  logic       in_tlast,   // last
  output logic       q_valid,
  output q_entry_t   q_entry,
  input  logic       q_pop
);

  q_entry_t        q_mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]   count_r, count_nxt;
  logic            accept;
  logic            push;
  logic            pop;

  // classify: a word with neither byte nor close has no effect
  assign in_tready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign accept    = in_tvalid & in_tready;
  assign push      = accept & (in_tuser | in_tlast);
  assign q_valid   = (count_r != '0);
  assign pop       = q_pop & q_valid;
  assign q_entry   = q_mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= '{data: in_tdata, has_byte: in_tuser, last: in_tlast};
    end
  end

endmodule

// ----- sv/sha256_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_back
// Block buffer, padding, one-round-per-cycle compression and digest register.
// ----------------------------------------------------------------------------
module sha256_back import sha256_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  q_entry_t            q_entry,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DIGEST_W-1:0] out_tdata
);

  state_t               state_r, state_nxt;
  blk_kind_t            kind_r, kind_nxt;
  logic                 pad_pend_r, pad_pend_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]          w_r [16];
  logic [31:0]          w_nxt [16];
  logic [31:0]          h_r [8];
  logic [31:0]          h_nxt [8];
  logic [31:0]          v_r [8];
  logic [31:0]          v_nxt [8];
  logic                 out_valid_r, out_valid_nxt;
  logic [DIGEST_W-1:0]  out_data_r, out_data_nxt;

  logic [5:0]  pos;
  logic [4:0]  lane_sh;
  logic [63:0] msg_len;
  logic [31:0] t1, t2, ch, maj, w_new;
  logic [31:0] h_sum [8];

  assign pos     = cnt_r[5:0];
  assign lane_sh = {~pos[1:0], 3'b000};
  assign msg_len = {cnt_r, 3'b000};

  // one compression round and the schedule step
  assign ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
  assign maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
  assign t1    = v_r[7] + big_sigma1(v_r[4]) + ch + K_TABLE[round_r] + w_r[0];
  assign t2    = big_sigma0(v_r[0]) + maj;
  assign w_new = small_sigma1(w_r[14]) + w_r[9] + small_sigma0(w_r[1]) + w_r[0];

  // chaining add at the end of a block
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_sum[i] = h_r[i] + v_r[i];
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pad_pend_nxt  = pad_pend_r;
    round_nxt     = round_r;
    cnt_nxt       = cnt_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_entry.has_byte) begin
            w_nxt[pos[5:2]][lane_sh +: 8] = q_entry.data;
            cnt_nxt = cnt_r + 1'b1;
            if (pos == 6'h3f) begin
              // full block, padding follows later if this word closes
              state_nxt    = ST_COMP;
              kind_nxt     = BK_DATA;
              pad_pend_nxt = q_entry.last;
              round_nxt    = '0;
              v_nxt        = h_r;
            end else if (q_entry.last) begin
              state_nxt = ST_PAD;
            end
          end else begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // pad marker, zeros after it, length if it still fits
        for (int i = 0; i < 64; i++) begin
          if (6'(i) == pos) begin
            w_nxt[i / 4][(3 - (i % 4)) * 8 +: 8] = PAD_BYTE;
          end else if (6'(i) > pos) begin
            w_nxt[i / 4][(3 - (i % 4)) * 8 +: 8] = 8'h00;
          end
        end
        if (pos[5:3] == 3'b111) begin
          kind_nxt = BK_PAD;
        end else begin
          w_nxt[14] = msg_len[63:32];
          w_nxt[15] = msg_len[31:0];
          kind_nxt  = BK_FINAL;
        end
        pad_pend_nxt = 1'b0;
        state_nxt    = ST_COMP;
        round_nxt    = '0;
        v_nxt        = h_r;
      end

      ST_LEN: begin
        // extra block: zeros and the length
        for (int i = 0; i < 14; i++) begin
          w_nxt[i] = '0;
        end
        w_nxt[14]  = msg_len[63:32];
        w_nxt[15]  = msg_len[31:0];
        kind_nxt   = BK_FINAL;
        state_nxt  = ST_COMP;
        round_nxt  = '0;
        v_nxt      = h_r;
      end

      ST_COMP: begin
        v_nxt[7] = v_r[6];
        v_nxt[6] = v_r[5];
        v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2];
        v_nxt[2] = v_r[1];
        v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[15] = w_new;
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        case (kind_r)
          BK_FINAL: begin
            // wait for the digest register to free up
            if (!out_valid_r || out_tready) begin
              for (int i = 0; i < 4; i++) begin
                out_data_nxt[64 * i +: 64] = {h_sum[2 * i], h_sum[2 * i + 1]};
              end
              out_valid_nxt = 1'b1;
              h_nxt         = H_INIT;
              cnt_nxt       = '0;
              state_nxt     = ST_IDLE;
            end
          end
          BK_PAD: begin
            h_nxt     = h_sum;
            state_nxt = ST_LEN;
          end
          default: begin
            h_nxt     = h_sum;
            state_nxt = pad_pend_r ? ST_PAD : ST_IDLE;
          end
        endcase
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kind_r      <= BK_DATA;
      pad_pend_r  <= 1'b0;
      round_r     <= '0;
      cnt_r       <= '0;
      h_r         <= H_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      pad_pend_r  <= pad_pend_nxt;
      round_r     <= round_nxt;
      cnt_r       <= cnt_nxt;
      h_r         <= h_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r        <= w_nxt;
    v_r        <= v_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- sv/sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Streaming SHA-256: message bytes in, 256-bit digest out.
// ----------------------------------------------------------------------------
// Input words carry one byte in in_tdata, in_tuser high when the byte belongs
// to the message, and in_tlast high on the word that closes the message. A
// word with in_tuser low and in_tlast high closes the message with the bytes
// already taken; one with both low is accepted and ignored.
// A four-word queue sits behind the input; the back end drains one byte per
// cycle while not padding or compressing. Every 64th byte starts a
// compression of 64 rounds, one per cycle, then the chaining add. The
// closing word adds a padding step and one compression, and a second block
// of zeros and the length, with its own compression, when 56 or more bytes
// are left in the last block. The digest then appears on out_tdata, digest
// bytes 0..7 big-endian in the lowest 64 bits, held in an output register.
// If the receiver stalls, the next message still streams in and is hashed;
// only its own digest waits until the register is free.
// Reset (rst_n low, synchronous) empties the queue, loads the initial hash
// words and clears the byte count; the buffer needs no clearing.
// ----------------------------------------------------------------------------
module sha256_stream_hasher import sha256_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,    // [7:0] data_byte
  input  logic                in_tuser,    // has_byte
  input  logic                in_tlast,    // last
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [DIGEST_W-1:0] out_tdata    // [63:0] digest_word_0, [127:64] digest_word_1,
                                           // [191:128] digest_word_2, [255:192] digest_word_3
);

  logic     q_valid;
  q_entry_t q_entry;
  logic     q_pop;

  sha256_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  sha256_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
